// ----- rtl/core/overwriting_byte_ring_fifo_core_assert.svh -----
// assertion macros shared by the byte ring fifo rtl
// no dependencies; the including module provides clk and rst_n
`ifndef OVERWRITING_BYTE_RING_FIFO_CORE_ASSERT_SVH
`define OVERWRITING_BYTE_RING_FIFO_CORE_ASSERT_SVH

// same-cycle implication, checked outside reset
`define OBRF_ASSERT_NOW(label, ante, cons) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
        else $error("obrf assertion failed");

// next-cycle implication, checked outside reset
`define OBRF_ASSERT_NEXT(label, ante, cons) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
        else $error("obrf assertion failed");

`endif

// ----- rtl/core/obrf_pkg.sv -----
// constants and types for the byte ring fifo core
// no dependencies
package obrf_pkg;

    localparam int MAX_CAPACITY = 1023;
    localparam int CAP_W        = 10;
    localparam int SLOT_DEPTH   = MAX_CAPACITY + 1;
    localparam int SLOT_W       = $clog2(SLOT_DEPTH);

    localparam logic [1:0] ACT_WRITE = 2'd0;
    localparam logic [1:0] ACT_READ  = 2'd1;
    localparam logic [1:0] ACT_PEEK  = 2'd2;
    localparam logic [1:0] ACT_CLEAR = 2'd3;

    typedef logic [SLOT_W-1:0] slot_t;

endpackage

// ----- rtl/core/obrf_ram.sv -----
// generic single-port ram with registered read data
// no dependencies
module obrf_ram #(
    parameter int WIDTH = 8,
    parameter int DEPTH = 1024
) (
    input  logic                     clk,
    input  logic                     en,
    input  logic                     we,
    input  logic [$clog2(DEPTH)-1:0] addr,
    input  logic [WIDTH-1:0]         wdata,
    output logic [WIDTH-1:0]         rdata
);

    logic [WIDTH-1:0] mem [DEPTH];
    logic [WIDTH-1:0] rdata_reg;

    always_ff @(posedge clk)
    begin
        if (en)
        begin
            if (we)
            begin
                mem[addr] <= wdata;
            end
            else
            begin
                rdata_reg <= mem[addr];
            end
        end
    end

    assign rdata = rdata_reg;

endmodule

// ----- rtl/core/overwriting_byte_ring_fifo_core.sv -----
// top level of the overwriting byte ring fifo
// depends on obrf_pkg, obrf_ram and overwriting_byte_ring_fifo_core_assert.svh

// Byte ring fifo holding up to "capacity" bytes (1..1023, reset 1023) in a
// single-port byte ram of 1024 slots; head points one slot before the oldest
// byte, tail at the newest. Each input transfer carries one action (write up
// to 4 bytes low byte first, read up to 4 bytes into a little-endian word,
// peek at one byte by position from the oldest, or clear) and gives exactly
// one output transfer with the read data, the byte count held afterwards and
// the empty and full flags. A write into a full fifo drops the oldest byte
// per pushed byte; a pop from an empty fifo yields a zero byte; a peek at or
// beyond the held count yields zero. Each byte moved takes one ram access on
// the single port; input is stalled while an item is in work, and a finished
// result may wait in the output register while the next item is accepted.
// Writing the capacity register empties the fifo and must only happen while
// no item is in work. The ram needs no clearing pass; a read only ever touches
// slots holding live bytes.

`include "overwriting_byte_ring_fifo_core_assert.svh"

module overwriting_byte_ring_fifo_core
    import obrf_pkg::*;
(
    input  logic             clk,
    input  logic             rst_n,
    // configuration
    input  logic             cfg_we,
    input  logic [CAP_W-1:0] cfg_wdata,
    // input channel
    input  logic             in_valid,
    output logic             in_stall,
    input  logic [1:0]       action,
    input  logic [2:0]       byte_count,
    input  logic [31:0]      write_data,
    input  logic [9:0]       peek_index,
    // output channel
    output logic             out_valid,
    input  logic             out_stall,
    output logic [31:0]      read_data,
    output logic [9:0]       used_count,
    output logic             is_empty,
    output logic             is_full
);

    // sequencer codes
    localparam logic [1:0] ST_IDLE   = 2'd0;
    localparam logic [1:0] ST_RUN    = 2'd1;
    localparam logic [1:0] ST_FINISH = 2'd2;

    logic [1:0]       state_reg, state_next;
    logic [CAP_W-1:0] capacity_reg, capacity_next;
    slot_t            head_reg, head_next;
    slot_t            tail_reg, tail_next;
    slot_t            used_reg, used_next;

    // latched item
    logic [1:0]       act_reg, act_next;
    logic [2:0]       count_reg, count_next;
    logic [2:0]       step_reg, step_next;
    logic [31:0]      data_reg, data_next;
    slot_t            pidx_reg, pidx_next;
    logic [31:0]      result_reg, result_next;

    // pending ram read, captured in the cycle after issue
    logic             cap_valid_reg, cap_valid_next;
    logic [1:0]       cap_lane_reg, cap_lane_next;

    // output register
    logic             out_valid_reg, out_valid_next;
    logic [31:0]      rd_data_reg, rd_data_next;
    slot_t            used_out_reg, used_out_next;
    logic             empty_reg, empty_next;
    logic             full_reg, full_next;

    // ram port
    logic             ram_en;
    logic             ram_we;
    slot_t            ram_addr;
    logic [7:0]       ram_wdata;
    logic [7:0]       ram_rdata;

    slot_t            eff_cap;
    slot_t            head_inc;
    slot_t            tail_inc;
    logic [SLOT_W:0]  peek_sum;
    logic [SLOT_W:0]  slot_count;
    slot_t            peek_addr;
    logic             in_accept;
    logic [2:0]       count_eff;

    // capacity zero behaves as one, anything above the store as the maximum
    always_comb
    begin
        if (capacity_reg == '0)
        begin
            eff_cap = slot_t'(1);
        end
        else if (capacity_reg > CAP_W'(MAX_CAPACITY))
        begin
            eff_cap = slot_t'(MAX_CAPACITY);
        end
        else
        begin
            eff_cap = slot_t'(capacity_reg);
        end
    end

    // ring has eff_cap + 1 slots, so the last slot index is eff_cap
    assign head_inc   = (head_reg == eff_cap) ? '0 : head_reg + slot_t'(1);
    assign tail_inc   = (tail_reg == eff_cap) ? '0 : tail_reg + slot_t'(1);
    assign slot_count = {1'b0, eff_cap} + (SLOT_W+1)'(1);
    assign peek_sum   = {1'b0, head_reg} + {1'b0, pidx_reg} + (SLOT_W+1)'(1);
    // with the index below the held count, head + index + 1 stays below twice the slot count
    assign peek_addr  = (peek_sum >= slot_count) ? SLOT_W'(peek_sum - slot_count)
                                                 : SLOT_W'(peek_sum);

    assign in_stall  = (state_reg != ST_IDLE);
    assign in_accept = in_valid && !in_stall;
    assign count_eff = (byte_count > 3'd4) ? 3'd4 : byte_count;

    always_comb
    begin
        state_next     = state_reg;
        capacity_next  = capacity_reg;
        head_next      = head_reg;
        tail_next      = tail_reg;
        used_next      = used_reg;
        act_next       = act_reg;
        count_next     = count_reg;
        step_next      = step_reg;
        data_next      = data_reg;
        pidx_next      = pidx_reg;
        result_next    = result_reg;
        cap_valid_next = 1'b0;
        cap_lane_next  = cap_lane_reg;
        out_valid_next = out_valid_reg && out_stall;
        rd_data_next   = rd_data_reg;
        used_out_next  = used_out_reg;
        empty_next     = empty_reg;
        full_next      = full_reg;
        ram_en         = 1'b0;
        ram_we         = 1'b0;
        ram_addr       = tail_reg;
        ram_wdata      = data_reg[{step_reg[1:0], 3'b000} +: 8];

        case (state_reg)
            ST_IDLE:
            begin
                if (in_accept)
                begin
                    act_next    = action;
                    data_next   = write_data;
                    pidx_next   = slot_t'(peek_index);
                    step_next   = '0;
                    result_next = '0;
                    state_next  = ST_RUN;
                    case (action)
                        ACT_PEEK:
                        begin
                            count_next = 3'd1;
                        end
                        ACT_CLEAR:
                        begin
                            count_next = 3'd0;
                            head_next  = tail_reg;
                            used_next  = '0;
                        end
                        default:
                        begin
                            count_next = count_eff;
                        end
                    endcase
                end
            end

            ST_RUN:
            begin
                // byte issued last cycle lands in its lane
                if (cap_valid_reg)
                begin
                    result_next[{cap_lane_reg, 3'b000} +: 8] = ram_rdata;
                end
                if (step_reg < count_reg)
                begin
                    step_next = step_reg + 3'd1;
                    case (act_reg)
                        ACT_WRITE:
                        begin
                            // full: the oldest byte is dropped before the push
                            if (used_reg == eff_cap)
                            begin
                                head_next = head_inc;
                            end
                            else
                            begin
                                used_next = used_reg + slot_t'(1);
                            end
                            tail_next = tail_inc;
                            ram_en    = 1'b1;
                            ram_we    = 1'b1;
                            ram_addr  = tail_inc;
                        end
                        ACT_READ:
                        begin
                            if (used_reg != '0)
                            begin
                                head_next      = head_inc;
                                used_next      = used_reg - slot_t'(1);
                                ram_en         = 1'b1;
                                ram_addr       = head_inc;
                                cap_valid_next = 1'b1;
                                cap_lane_next  = step_reg[1:0];
                            end
                        end
                        ACT_PEEK:
                        begin
                            if (pidx_reg < used_reg)
                            begin
                                ram_en         = 1'b1;
                                ram_addr       = peek_addr;
                                cap_valid_next = 1'b1;
                                cap_lane_next  = 2'd0;
                            end
                        end
                        default:
                        begin
                        end
                    endcase
                end
                else
                begin
                    state_next = ST_FINISH;
                end
            end

            ST_FINISH:
            begin
                // wait for the output register to free up
                if (!out_valid_reg || !out_stall)
                begin
                    out_valid_next = 1'b1;
                    rd_data_next   = result_reg;
                    used_out_next  = used_reg;
                    empty_next     = (used_reg == '0);
                    full_next      = (used_reg == eff_cap);
                    state_next     = ST_IDLE;
                end
            end

            default:
            begin
                state_next = ST_IDLE;
            end
        endcase

        // capacity write empties the fifo; the user must only issue it while idle, the block does not enforce this
        if (cfg_we)
        begin
            capacity_next = cfg_wdata;
            head_next     = '0;
            tail_next     = '0;
            used_next     = '0;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg     <= ST_IDLE;
            capacity_reg  <= CAP_W'(MAX_CAPACITY);
            head_reg      <= '0;
            tail_reg      <= '0;
            used_reg      <= '0;
            step_reg      <= '0;
            count_reg     <= '0;
            act_reg       <= ACT_WRITE;
            cap_valid_reg <= 1'b0;
            out_valid_reg <= 1'b0;
        end
        else
        begin
            state_reg     <= state_next;
            capacity_reg  <= capacity_next;
            head_reg      <= head_next;
            tail_reg      <= tail_next;
            used_reg      <= used_next;
            step_reg      <= step_next;
            count_reg     <= count_next;
            act_reg       <= act_next;
            cap_valid_reg <= cap_valid_next;
            out_valid_reg <= out_valid_next;
        end
    end

    // payload registers
    always_ff @(posedge clk)
    begin
        data_reg     <= data_next;
        pidx_reg     <= pidx_next;
        result_reg   <= result_next;
        cap_lane_reg <= cap_lane_next;
        rd_data_reg  <= rd_data_next;
        used_out_reg <= used_out_next;
        empty_reg    <= empty_next;
        full_reg     <= full_next;
    end

    obrf_ram #(
        .WIDTH (8),
        .DEPTH (SLOT_DEPTH)
    ) u_store (
        .clk   (clk),
        .en    (ram_en),
        .we    (ram_we),
        .addr  (ram_addr),
        .wdata (ram_wdata),
        .rdata (ram_rdata)
    );

    assign out_valid  = out_valid_reg;
    assign read_data  = rd_data_reg;
    assign used_count = 10'(used_out_reg);
    assign is_empty   = empty_reg;
    assign is_full    = full_reg;

    // held count must agree with the ring pointers
    logic [SLOT_W:0] ptr_span;
    assign ptr_span = (tail_reg >= head_reg)
                    ? {1'b0, tail_reg} - {1'b0, head_reg}
                    : {1'b0, tail_reg} + slot_count - {1'b0, head_reg};

    `OBRF_ASSERT_NOW(a_used_in_range, 1'b1, used_reg <= eff_cap)
    `OBRF_ASSERT_NOW(a_ptrs_in_ring, 1'b1, (head_reg <= eff_cap) && (tail_reg <= eff_cap))
    `OBRF_ASSERT_NOW(a_used_matches_ptrs, 1'b1, ptr_span == {1'b0, used_reg})
    `OBRF_ASSERT_NEXT(a_accept_starts_work, in_accept, state_reg == ST_RUN)
    `OBRF_ASSERT_NOW(a_ram_only_in_run, ram_en, state_reg == ST_RUN)

endmodule
